// ===== design/rcs_pkg.sv =====
// Shared types, constants and the reciprocal table of the RGB to CMYK separator.
`default_nettype none

package rcs_pkg;

   // Field widths
   localparam int PIX_W       = 8;
   localparam int GAIN_W      = 12;
   localparam int CSR_INDEX_W = 4;
   localparam int NUM_GAINS   = 4;

   // Gain defaults: 1.0 in Q4.8
   localparam int                GAIN_FRAC_BITS_DEFAULT = 8;
   localparam logic [GAIN_W-1:0] GAIN_RESET             = 12'd256;

   // Reciprocal arithmetic widths
   localparam int NUM_W   = 2 * PIX_W;        // (mx - ch) * 255
   localparam int RECIP_W = NUM_W + 1;        // floor(2^16 / mx), up to 2^16
   localparam int PROD_W  = NUM_W + RECIP_W;
   localparam int DEPTH   = 1 << PIX_W;

   // Channel order in the ink arrays
   localparam int INK_CYAN    = 0;
   localparam int INK_MAGENTA = 1;
   localparam int INK_YELLOW  = 2;
   localparam int INK_BLACK   = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CYAN_GAIN    = 4'd0,
      CSR_MAGENTA_GAIN = 4'd1,
      CSR_YELLOW_GAIN  = 4'd2,
      CSR_BLACK_GAIN   = 4'd3
   } csr_index_type;

   typedef logic [DEPTH-1:0][RECIP_W-1:0] recip_table_type;

   // Build floor(2^NUM_W / d) for every divisor by restoring division
   function automatic recip_table_type build_recip();
      recip_table_type tbl;
      logic [RECIP_W:0] rem;
      logic [RECIP_W-1:0] quo;
      logic [RECIP_W-1:0] dividend;
      tbl = '0;
      dividend = RECIP_W'(1) << NUM_W;
      for (int d = 1; d < DEPTH; d++) begin
         rem = '0;
         quo = '0;
         for (int i = RECIP_W - 1; i >= 0; i--) begin
            rem = {rem[RECIP_W-1:0], dividend[i]};
            if (rem >= (RECIP_W + 1)'(d)) begin
               rem = rem - (RECIP_W + 1)'(d);
               quo[i] = 1'b1;
            end
         end
         tbl[d] = quo;
      end
      return tbl;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip();

endpackage

`default_nettype wire

// ===== design/rcs_if.sv =====
// Handshake channels of the separator: pixel requests, ink responses, gain writes.
`default_nettype none

interface rcs_req_if
   import rcs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] red_in;

   modport source (output valid, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface rcs_rsp_if
   import rcs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] cyan_level;
   logic [PIX_W-1:0] magenta_level;
   logic [PIX_W-1:0] yellow_level;
   logic [PIX_W-1:0] black_level;

   modport source (output valid, cyan_level, magenta_level, yellow_level, black_level,
                   input ready);
   modport sink   (input valid, cyan_level, magenta_level, yellow_level, black_level,
                   output ready);
endinterface

interface rcs_csr_if
   import rcs_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [GAIN_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/rcs_ink_div.sv =====
// Three-stage pipelined floor((mx - ch) * 255 / mx) by reciprocal multiply and correction.
`default_nettype none

module rcs_ink_div
   import rcs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire logic [PIX_W-1:0] max_in,
   input  wire logic [PIX_W-1:0] diff_in,
   output logic      [PIX_W-1:0] raw_out
);

   logic [NUM_W-1:0]   num1_ff,   num1_in;
   logic [RECIP_W-1:0] recip1_ff, recip1_in;
   logic [PIX_W-1:0]   max1_ff;
   logic [NUM_W-1:0]   num2_ff;
   logic [PIX_W-1:0]   max2_ff;
   logic [PIX_W-1:0]   quo2_ff,   quo2_in;
   logic [PIX_W-1:0]   raw3_ff,   raw3_in;
   logic [PROD_W-1:0]  prod;
   logic [NUM_W-1:0]   quo_times_max;
   logic [NUM_W-1:0]   rem;

   // Stage 1: numerator times 255 and reciprocal lookup
   assign num1_in   = {diff_in, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff_in};
   assign recip1_in = RECIP_TABLE[max_in];

   // Stage 2: estimate quotient, low by at most one
   assign prod    = {{RECIP_W{1'b0}}, num1_ff} * {{NUM_W{1'b0}}, recip1_ff};
   assign quo2_in = prod[NUM_W +: PIX_W];

   // Stage 3: remainder check and correction, black pixel gives zero
   assign quo_times_max = {{PIX_W{1'b0}}, quo2_ff} * {{PIX_W{1'b0}}, max2_ff};
   assign rem           = num2_ff - quo_times_max;

   always_comb begin
      if (max2_ff == '0) begin
         raw3_in = '0;
      end else if (rem >= {{PIX_W{1'b0}}, max2_ff}) begin
         raw3_in = quo2_ff + PIX_W'(1);
      end else begin
         raw3_in = quo2_ff;
      end
   end

   // Advance all stages together, hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         num1_ff   <= num1_in;
         recip1_ff <= recip1_in;
         max1_ff   <= max_in;
         num2_ff   <= num1_ff;
         max2_ff   <= max1_ff;
         quo2_ff   <= quo2_in;
         raw3_ff   <= raw3_in;
      end
   end

   assign raw_out = raw3_ff;

endmodule

`default_nettype wire

// ===== design/rgb_to_cmyk_separator_core.sv =====
// Top level of the RGB to CMYK separator: gain registers and the pixel pipeline.
//
//   channel   direction  payload                                    handshake
//   req_bus   in         blue_in, green_in, red_in (8 b each)       valid/ready
//   rsp_bus   out        cyan/magenta/yellow/black_level (8 b each) valid/ready
//   csr_bus   in         index (4 b), data (12 b gain)              valid/ready
//
// One pixel per clock enters while the response is not stalled; each result passes
// the input register, the max stage, the three divider stages and the gain stage
// feeding the output register.
// Reset clears the valid bits and sets every gain to 1.0.
// A stalled response freezes the whole pipeline; req ready follows it.
`default_nettype none

module rgb_to_cmyk_separator_core
   import rcs_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   rcs_req_if.sink   req_bus,
   rcs_rsp_if.source rsp_bus,
   rcs_csr_if.sink   csr_bus
);

   localparam int STAGES   = 6;
   localparam int SCALED_W = PIX_W + GAIN_W - GAIN_FRAC_BITS;
   localparam int MULT_W   = PIX_W + GAIN_W;

   logic [GAIN_W-1:0] gain_ff [NUM_GAINS];
   logic [STAGES-1:0] valid_ff;
   logic              advance;

   logic [PIX_W-1:0] blue0_ff, green0_ff, red0_ff;
   logic [PIX_W-1:0] max_in;
   logic [PIX_W-1:0] max1_ff;
   logic [PIX_W-1:0] diff1_ff [3];
   logic [PIX_W-1:0] black1_ff, black2_ff, black3_ff, black4_ff;
   logic [PIX_W-1:0] raw [NUM_GAINS];
   logic [PIX_W-1:0] level_in [NUM_GAINS];
   logic [PIX_W-1:0] level_ff [NUM_GAINS];

   // Gain registers, writes beyond the list dropped
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GAINS; i++) begin
            gain_ff[i] <= GAIN_RESET;
         end
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_CYAN_GAIN:    gain_ff[INK_CYAN]    <= csr_bus.data;
            CSR_MAGENTA_GAIN: gain_ff[INK_MAGENTA] <= csr_bus.data;
            CSR_YELLOW_GAIN:  gain_ff[INK_YELLOW]  <= csr_bus.data;
            CSR_BLACK_GAIN:   gain_ff[INK_BLACK]   <= csr_bus.data;
            default:          ;
         endcase
      end
   end

   // Pipeline advances unless the output holds an untaken result
   assign advance       = !valid_ff[STAGES-1] || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], req_bus.valid};
      end
   end

   // Largest channel and differences
   always_comb begin
      max_in = red0_ff;
      if (green0_ff > max_in) max_in = green0_ff;
      if (blue0_ff > max_in)  max_in = blue0_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         blue0_ff             <= req_bus.blue_in;
         green0_ff            <= req_bus.green_in;
         red0_ff              <= req_bus.red_in;
         max1_ff              <= max_in;
         diff1_ff[INK_CYAN]    <= max_in - red0_ff;
         diff1_ff[INK_MAGENTA] <= max_in - green0_ff;
         diff1_ff[INK_YELLOW]  <= max_in - blue0_ff;
         black1_ff            <= ~max_in;
         black2_ff            <= black1_ff;
         black3_ff            <= black2_ff;
         black4_ff            <= black3_ff;
      end
   end

   // Chroma dividers, one per colour ink
   for (genvar c = 0; c < 3; c++) begin : g_div
      rcs_ink_div u_div (
         .clock   (clock),
         .advance (advance),
         .max_in  (max1_ff),
         .diff_in (diff1_ff[c]),
         .raw_out (raw[c])
      );
   end

   assign raw[INK_BLACK] = black4_ff;

   // Scale by gain, saturate and invert
   for (genvar k = 0; k < NUM_GAINS; k++) begin : g_scale
      logic [MULT_W-1:0]   mult;
      logic [SCALED_W-1:0] scaled;
      assign mult   = {{GAIN_W{1'b0}}, raw[k]} * {{PIX_W{1'b0}}, gain_ff[k]};
      assign scaled = mult[MULT_W-1:GAIN_FRAC_BITS];
      assign level_in[k] = (scaled > SCALED_W'(255)) ? '0 : ~scaled[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_GAINS; i++) begin
            level_ff[i] <= level_in[i];
         end
      end
   end

   assign rsp_bus.valid         = valid_ff[STAGES-1];
   assign rsp_bus.cyan_level    = level_ff[INK_CYAN];
   assign rsp_bus.magenta_level = level_ff[INK_MAGENTA];
   assign rsp_bus.yellow_level  = level_ff[INK_YELLOW];
   assign rsp_bus.black_level   = level_ff[INK_BLACK];

   // Checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> valid_ff[0])
      else $error("accepted pixel did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("valid bits moved during a stall");

   a_black_gain_write: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready && csr_bus.index == CSR_BLACK_GAIN)
      |=> gain_ff[INK_BLACK] == $past(csr_bus.data))
      else $error("black gain write lost");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the RGB to CMYK separator: directed table, random pixels, gain sweeps.

module tb_top;
   import rcs_pkg::*;

   localparam int GAIN_SHIFT    = GAIN_FRAC_BITS_DEFAULT;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 50;
   localparam int LONG_HOLD     = 60;
   localparam int SETTLE_CYCLES = 12;
   localparam int TIMEOUT_NS    = 3_000_000;
   localparam int PLAN_LEN      = 31;
   localparam logic [PIX_W-1:0]       PIX_MAX  = '1;
   localparam logic [GAIN_W-1:0]      GAIN_MAX = '1;
   // No gain register sits at this index
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG = '1;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] cyan;
      logic [PIX_W-1:0] magenta;
      logic [PIX_W-1:0] yellow;
      logic [PIX_W-1:0] black;
   } ink_levels_type;

   typedef enum logic {ROW_PIXEL, ROW_GAIN} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [GAIN_W-1:0]      gain;
      pixel_type              px;
      logic                   known;
      ink_levels_type         want;
   } plan_row_type;

   // Directed plan: expected levels typed in only where obvious, else predicted
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // reset gains: black, white, primaries, grey
      '{ROW_PIXEL, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
      '{ROW_PIXEL, '0, '0, '{8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd255, 8'd255, 8'd255, 8'd255}},
      '{ROW_PIXEL, '0, '0, '{8'd0, 8'd0, 8'd255}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd255}},
      '{ROW_PIXEL, '0, '0, '{8'd0, 8'd255, 8'd0}, 1'b1, '{8'd0, 8'd255, 8'd0, 8'd255}},
      '{ROW_PIXEL, '0, '0, '{8'd255, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd255, 8'd255}},
      '{ROW_PIXEL, '0, '0, '{8'd128, 8'd128, 8'd128}, 1'b1,
        '{8'd255, 8'd255, 8'd255, 8'd128}},
      '{ROW_PIXEL, '0, '0, '{8'd1, 8'd0, 8'd0}, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'd10, 8'd200, 8'd77}, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'hAA, 8'h55, 8'h3C}, 1'b0, '0},
      // zero gain everywhere: no ink at all
      '{ROW_GAIN, CSR_CYAN_GAIN,    12'd0, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_MAGENTA_GAIN, 12'd0, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_YELLOW_GAIN,  12'd0, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_BLACK_GAIN,   12'd0, '0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'd10, 8'd200, 8'd77}, 1'b1,
        '{8'd255, 8'd255, 8'd255, 8'd255}},
      '{ROW_PIXEL, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
      // largest gain: overflow saturates to full ink
      '{ROW_GAIN, CSR_CYAN_GAIN,    GAIN_MAX, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_MAGENTA_GAIN, GAIN_MAX, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_YELLOW_GAIN,  GAIN_MAX, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_BLACK_GAIN,   GAIN_MAX, '0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'd0, 8'd128, 8'd255}, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd255}},
      '{ROW_PIXEL, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
      '{ROW_PIXEL, '0, '0, '{8'd77, 8'd33, 8'd190}, 1'b0, '0},
      // write to an index with no register: must change nothing
      '{ROW_GAIN, CSR_NO_REG, 12'd0, '0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
      // mixed gains
      '{ROW_GAIN, CSR_CYAN_GAIN,    12'd128, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_MAGENTA_GAIN, 12'd512, '0, 1'b0, '0},
      '{ROW_GAIN, CSR_YELLOW_GAIN,  12'd1,   '0, 1'b0, '0},
      '{ROW_GAIN, CSR_BLACK_GAIN,   12'd200, '0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'd60, 8'd120, 8'd180}, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'h55, 8'hAA, 8'hC3}, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, '{8'hFF, 8'h01, 8'h00}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcs_req_if req_bus ();
   rcs_rsp_if rsp_bus ();
   rcs_csr_if csr_bus ();

   rgb_to_cmyk_separator_core #(
      .GAIN_FRAC_BITS(GAIN_SHIFT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   logic [GAIN_W-1:0] gain_regs [NUM_GAINS];
   ink_levels_type    expected_inks [$];
   int                failures      = 0;
   int                req_idle_pct  = 0;
   int                rsp_stall_pct = 0;
   bit                hold_request  = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Share of one ink relative to the strongest channel, 0..255
   function automatic logic [PIX_W-1:0] ink_share(input logic [PIX_W-1:0] peak,
                                                  input logic [PIX_W-1:0] chan);
      logic [2*PIX_W-1:0] num;
      if (peak == '0) return '0;
      num = (16'(peak) - 16'(chan)) * 16'(PIX_MAX);
      return PIX_W'(num / 16'(peak));
   endfunction

   // Apply gain, saturate and invert
   function automatic logic [PIX_W-1:0] ink_after_gain(input logic [PIX_W-1:0] raw,
                                                       input logic [GAIN_W-1:0] gain);
      logic [PIX_W+GAIN_W-1:0] scaled;
      scaled = (20'(raw) * 20'(gain)) >> GAIN_SHIFT;
      if (scaled > 20'(PIX_MAX)) scaled = 20'(PIX_MAX);
      return PIX_MAX - PIX_W'(scaled);
   endfunction

   function automatic ink_levels_type predict_inks(input pixel_type px);
      logic [PIX_W-1:0] peak;
      ink_levels_type   lv;
      peak = px.red;
      if (px.green > peak) peak = px.green;
      if (px.blue > peak) peak = px.blue;
      lv.cyan    = ink_after_gain(ink_share(peak, px.red), gain_regs[CSR_CYAN_GAIN]);
      lv.magenta = ink_after_gain(ink_share(peak, px.green), gain_regs[CSR_MAGENTA_GAIN]);
      lv.yellow  = ink_after_gain(ink_share(peak, px.blue), gain_regs[CSR_YELLOW_GAIN]);
      lv.black   = ink_after_gain(PIX_MAX - peak, gain_regs[CSR_BLACK_GAIN]);
      return lv;
   endfunction

   // Uniform random pixels, with greys, dark, saturated and zero channels mixed in
   function automatic pixel_type random_pixel();
      pixel_type px;
      px.blue  = PIX_W'($urandom_range(255));
      px.green = PIX_W'($urandom_range(255));
      px.red   = PIX_W'($urandom_range(255));
      case ($urandom_range(9))
         0: begin
            px.green = px.blue;
            px.red   = px.blue;
         end
         1: px.red = '0;
         2: px.green = PIX_MAX;
         3: px = px & 24'h070707;
         4: px = '0;
         5: px.blue = '0;
         default: ;
      endcase
      return px;
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(5))
         0: return '0;
         1: return GAIN_MAX;
         2: return GAIN_RESET;
         default: return GAIN_W'($urandom_range(4095));
      endcase
   endfunction

   // Offer one pixel, idling first at random; record its expectation on transfer
   task automatic send_pixel(input pixel_type px, input bit known,
                             input ink_levels_type want);
      ink_levels_type next_inks;
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.blue_in  <= px.blue;
      req_bus.green_in <= px.green;
      req_bus.red_in   <= px.red;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      next_inks     = known ? want : predict_inks(px);
      expected_inks = {expected_inks, next_inks};
   endtask

   // Drop valid and hold until every outstanding result has arrived
   task automatic wait_for_inks();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_inks.size() != 0) @(posedge clock);
   endtask

   task automatic write_gain(input logic [CSR_INDEX_W-1:0] index,
                             input logic [GAIN_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (index < NUM_GAINS) gain_regs[index] = value;
      @(posedge clock);
   endtask

   task automatic check_level(input string name, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : ink_checker
      ink_levels_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_inks.size() == 0) begin
            $display("%0t ns: unexpected ink result %0d %0d %0d %0d", $time,
                     rsp_bus.cyan_level, rsp_bus.magenta_level,
                     rsp_bus.yellow_level, rsp_bus.black_level);
            failures++;
         end else begin
            want = expected_inks.pop_front();
            check_level("cyan_level", want.cyan, rsp_bus.cyan_level);
            check_level("magenta_level", want.magenta, rsp_bus.magenta_level);
            check_level("yellow_level", want.yellow, rsp_bus.yellow_level);
            check_level("black_level", want.black, rsp_bus.black_level);
         end
      end
   end

   initial begin : main_flow
      logic [GAIN_W-1:0] gain_val;
      req_bus.valid    = 1'b0;
      req_bus.blue_in  = '0;
      req_bus.green_in = '0;
      req_bus.red_in   = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      foreach (gain_regs[g]) gain_regs[g] = GAIN_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan; gain writes only once the pipeline is empty
      foreach (PLAN[n]) begin
         if (PLAN[n].kind == ROW_GAIN) begin
            wait_for_inks();
            write_gain(PLAN[n].index, PLAN[n].gain);
         end else begin
            send_pixel(PLAN[n].px, PLAN[n].known, PLAN[n].want);
         end
      end

      // Random pixel phases: gains rewritten and the idling pattern changed each time
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_inks();
         for (int g = 0; g < NUM_GAINS; g++) begin
            case (p)
               0: gain_val = GAIN_RESET;
               1: gain_val = GAIN_MAX;
               2: gain_val = '0;
               default: gain_val = random_gain();
            endcase
            write_gain(CSR_INDEX_W'(g), gain_val);
         end
         write_gain(CSR_INDEX_W'($urandom_range(NUM_GAINS, (1 << CSR_INDEX_W) - 1)),
                    random_gain());
         case (p % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 55;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 55;
            end
            default: begin
               req_idle_pct  = 37;
               rsp_stall_pct = 37;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // fill the pipeline behind a long receiver hold-off
            if (p == 0 && i == 10) hold_request = 1'b1;
            // pause the sender until everything is back
            if (p == 5 && i == 25) wait_for_inks();
            send_pixel(random_pixel(), 1'b0, '0);
         end
      end

      wait_for_inks();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", expected_inks.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
